// ----- rtl/kvt_pkg.sv -----
// Shared types and constants of the key/value table.
package kvt_pkg;

  localparam int CAPACITY        = 16;
  localparam int KEY_W           = 32;
  localparam int VALUE_W         = 32;
  localparam int MODE_W          = 2;
  localparam int STATUS_W        = 3;
  localparam int ENTRY_COUNT_W   = 5;
  localparam int CNT_W           = $clog2(CAPACITY + 1);
  localparam int CNT_EXT_W       = (CNT_W > ENTRY_COUNT_W) ? CNT_W : ENTRY_COUNT_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_INSERTED  = 3'd0,
    STAT_UPDATED   = 3'd1,
    STAT_FOUND     = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_REMOVED   = 3'd4,
    STAT_FULL      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_RES
  } state_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                      wr_new;
    logic                      wr_upd;
    logic                      rm;
    logic signed [KEY_W-1:0]   key;
    logic        [VALUE_W-1:0] value;
  } cell_cmd_t;

  // carried from each cell to its right-hand neighbor
  typedef struct packed {
    logic               hit;
    logic               free;
    logic [VALUE_W-1:0] value;
  } link_t;

endpackage

// ----- rtl/kvt_req_if.sv -----
// Request and response channel interfaces of the key/value table.
interface kvt_req_if;
  logic                               valid;
  logic                               ready;
  logic        [kvt_pkg::MODE_W-1:0]  mode;
  logic signed [kvt_pkg::KEY_W-1:0]   key;
  logic        [kvt_pkg::VALUE_W-1:0] value;

  modport source (output valid, output mode, output key, output value, input ready);
  modport sink   (input valid, input mode, input key, input value, output ready);
endinterface

interface kvt_rsp_if;
  logic                                     valid;
  logic                                     ready;
  logic [kvt_pkg::STATUS_W-1:0]             status;
  logic [kvt_pkg::VALUE_W-1:0]              value_out;
  logic [kvt_pkg::ENTRY_COUNT_W-1:0]        entry_count;

  modport source (output valid, output status, output value_out, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input value_out, input entry_count,
                  output ready);
endinterface

// ----- rtl/key_value_table_top.sv -----
// Associative key/value table: request control, result register and cell row.
// Flow: the request is registered on accept; each cell registers its key compare,
//   then the cell chain resolves hit, first free cell and read value, and the result
//   register loads once the output slot is free; no new request is taken before that.
// Reset: synchronous, clears every valid bit and the entry count at once;
//   no clearing pass, stored keys and values are not reset.
module key_value_table_top (
  input  logic      clk,
  input  logic      rst_n,
  kvt_req_if.sink   in_req,
  kvt_rsp_if.source out_rsp
);

  kvt_pkg::state_t                     state_r, state_nxt;
  logic        [kvt_pkg::MODE_W-1:0]   req_mode_r;
  logic signed [kvt_pkg::KEY_W-1:0]    req_key_r;
  logic        [kvt_pkg::VALUE_W-1:0]  req_value_r;
  logic        [kvt_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic                                out_valid_r;
  kvt_pkg::status_t                    out_status_r, status_nxt;
  logic        [kvt_pkg::VALUE_W-1:0]  out_value_r, value_nxt;
  logic        [kvt_pkg::CNT_W-1:0]    out_count_r;

  kvt_pkg::cell_cmd_t cmd;
  kvt_pkg::link_t     tail;
  logic               in_acc;
  logic               slot_free;
  logic               commit;
  logic               ins_new;
  logic               rm_hit;

  assign slot_free = !out_valid_r || out_rsp.ready;
  assign in_acc    = in_req.valid && in_req.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kvt_pkg::S_IDLE: if (in_acc) state_nxt = kvt_pkg::S_CMP;
      kvt_pkg::S_CMP:  state_nxt = kvt_pkg::S_RES;
      kvt_pkg::S_RES: begin
        if (slot_free) state_nxt = in_acc ? kvt_pkg::S_CMP : kvt_pkg::S_IDLE;
      end
      default: state_nxt = kvt_pkg::S_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_req.ready = 1'b0;
    commit       = 1'b0;
    unique case (state_r)
      kvt_pkg::S_IDLE: in_req.ready = 1'b1;
      kvt_pkg::S_CMP:  in_req.ready = 1'b0;
      kvt_pkg::S_RES: begin
        in_req.ready = slot_free;
        commit       = slot_free;
      end
      default: in_req.ready = 1'b0;
    endcase
  end

  // result resolve
  always_comb begin
    cmd.wr_new = 1'b0;
    cmd.wr_upd = 1'b0;
    cmd.rm     = 1'b0;
    cmd.key    = req_key_r;
    cmd.value  = req_value_r;
    status_nxt = kvt_pkg::STAT_NOT_FOUND;
    value_nxt  = '0;
    unique case (kvt_pkg::mode_t'(req_mode_r))
      kvt_pkg::MODE_INSERT: begin
        cmd.wr_upd = commit && tail.hit;
        cmd.wr_new = commit && !tail.hit;
        if (tail.hit)       status_nxt = kvt_pkg::STAT_UPDATED;
        else if (tail.free) status_nxt = kvt_pkg::STAT_INSERTED;
        else                status_nxt = kvt_pkg::STAT_FULL;
      end
      kvt_pkg::MODE_LOOKUP: begin
        if (tail.hit) begin
          status_nxt = kvt_pkg::STAT_FOUND;
          value_nxt  = tail.value;
        end
      end
      kvt_pkg::MODE_REMOVE: begin
        cmd.rm = commit && tail.hit;
        if (tail.hit) status_nxt = kvt_pkg::STAT_REMOVED;
      end
      default: status_nxt = kvt_pkg::STAT_NOT_FOUND;
    endcase
  end

  assign ins_new   = cmd.wr_new && tail.free;
  assign rm_hit    = cmd.rm;
  assign count_nxt = count_r + kvt_pkg::CNT_W'(ins_new) - kvt_pkg::CNT_W'(rm_hit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kvt_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_mode_r  <= in_req.mode;
      req_key_r   <= in_req.key;
      req_value_r <= in_req.value;
    end
    if (commit) begin
      out_status_r <= status_nxt;
      out_value_r  <= value_nxt;
      out_count_r  <= count_nxt;
    end
  end

  kvt_cell_row u_row (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .tail  (tail)
  );

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.value_out   = out_value_r;
  assign out_rsp.entry_count =
    kvt_pkg::ENTRY_COUNT_W'(kvt_pkg::CNT_EXT_W'(out_count_r));

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= kvt_pkg::CNT_W'(kvt_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> $stable(count_r))
    else $error("entry count changed without a commit");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && status_nxt == kvt_pkg::STAT_INSERTED) |=>
      count_r == $past(count_r) + kvt_pkg::CNT_W'(1))
    else $error("insert did not bump entry count");

  a_full_no_free: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && status_nxt == kvt_pkg::STAT_FULL) |->
      (count_r == kvt_pkg::CNT_W'(kvt_pkg::CAPACITY)))
    else $error("table full reported with free cells");

endmodule

// ----- rtl/kvt_cell.sv -----
// One table cell: stored key, value and valid bit, with its link to the next cell.
module kvt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  kvt_pkg::cell_cmd_t cmd,
  input  kvt_pkg::link_t     link_i,
  output kvt_pkg::link_t     link_o
);

  logic                               valid_r;
  logic                               match_r;
  logic signed [kvt_pkg::KEY_W-1:0]   key_r;
  logic        [kvt_pkg::VALUE_W-1:0] value_r;
  logic                               claim;

  // first free cell from the left takes a new key
  assign claim = !valid_r && !link_i.free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      match_r <= valid_r && (key_r == cmd.key);
      if (cmd.wr_new && claim) begin
        valid_r <= 1'b1;
      end else if (cmd.rm && match_r) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_new && claim) begin
      key_r   <= cmd.key;
      value_r <= cmd.value;
    end else if (cmd.wr_upd && match_r) begin
      value_r <= cmd.value;
    end
  end

  assign link_o.hit   = link_i.hit || match_r;
  assign link_o.free  = link_i.free || !valid_r;
  assign link_o.value = link_i.value | (match_r ? value_r : '0);

endmodule

// ----- rtl/kvt_cell_row.sv -----
// Row of table cells chained left to right.
module kvt_cell_row (
  input  logic               clk,
  input  logic               rst_n,
  input  kvt_pkg::cell_cmd_t cmd,
  output kvt_pkg::link_t     tail
);

  kvt_pkg::link_t links [kvt_pkg::CAPACITY+1];

  assign links[0] = '0;

  for (genvar i = 0; i < kvt_pkg::CAPACITY; i++) begin : g_cell
    kvt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .link_i (links[i]),
      .link_o (links[i+1])
    );
  end

  assign tail = links[kvt_pkg::CAPACITY];

endmodule
